// File: rtl/wta_pkg.sv
// ----------------------------------------------------------------------------
// wta_pkg: shared widths and types for the window trigger and average core
// Holds the window size, derived widths, register indexes and the structs
// that travel between the cells and the top level.
// ----------------------------------------------------------------------------
package wta_pkg;

    localparam int WINDOW    = 8;
    localparam int SAMPLE_W  = 10;
    localparam int BASE_W    = 10;
    localparam int THR_W     = 11;
    localparam int HELD_W    = 4;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int DIFF_W    = SAMPLE_W + 2;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_THR  = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_cell_data;

    typedef struct packed {
        logic [BASE_W-1:0]       base;
        logic signed [THR_W-1:0] thr;
    } t_cmp_cfg;

endpackage

// File: rtl/window_trigger_and_average_core.sv
// ----------------------------------------------------------------------------
// window_trigger_and_average_core: sliding window mean with vote trigger
//
// Input channel: i_in_valid / o_in_ready carry one 10-bit sample per beat.
// Output channel: o_out_valid / i_out_ready carry triggered, average and
// held_count, one result beat per input beat, in order.
// Configuration: i_cfg_we writes base value (index 0) or trigger threshold
// (index 1) from i_cfg_data; write only while the core is idle.
// The window is a row of slot cells; a new sample enters at the head and
// the oldest drops off the tail once all slots hold data. A running sum
// tracks the window; slot votes are counted in the cycle after the push.
// The mean is formed by a divider that produces one quotient bit per
// cycle. One item is in work at a time; the next sample is taken as
// soon as the result moves to the output register, even if that
// register waits. If the receiver stalls, the finished result holds in
// the divider until the output register frees up.
// Reset clears all slots, the fill count, the sum and both registers.
// ----------------------------------------------------------------------------
module window_trigger_and_average_core
    import wta_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_triggered,
    output logic [SAMPLE_W-1:0] o_average,
    output logic [HELD_W-1:0]   o_held_count,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    t_cmp_cfg            r_cmp;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic                r_trig;
    logic                r_out_valid;
    logic                r_out_trig;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic [HELD_W-1:0]   r_out_held;

    t_cell_data          w_chain [WINDOW+1];
    logic [WINDOW-1:0]   w_votes;
    logic                w_accept;
    logic                w_full;
    logic [SAMPLE_W-1:0] w_drop;
    logic [CNT_W-1:0]    w_vote_cnt;
    logic [CNT_W+1:0]    w_vote_x3;
    logic                w_div_busy;
    logic [SUM_W-1:0]    w_quo;
    logic                w_load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_fill == CNT_W'(WINDOW));

    assign w_chain[0].valid  = 1'b1;
    assign w_chain[0].sample = i_sample;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        wta_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_prev  (w_chain[g]),
            .i_cmp   (r_cmp),
            .o_data  (w_chain[g+1]),
            .o_vote  (w_votes[g])
        );
    end

    // tail slot leaves the window only when every slot is in use
    assign w_drop = w_full ? w_chain[WINDOW].sample : '0;

    assign w_vote_cnt = CNT_W'($countones(w_votes));
    assign w_vote_x3  = {w_vote_cnt, 1'b0} + {2'b00, w_vote_cnt};

    wta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_COUNT),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_load_out = (r_state == S_DIV) && !w_div_busy
                        && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_cmp.base  <= '0;
            r_cmp.thr   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE: r_cmp.base <= i_cfg_data[BASE_W-1:0];
                    REG_THR:  r_cmp.thr  <= i_cfg_data[THR_W-1:0];
                    default:  r_cmp      <= r_cmp;
                endcase
            end
            if (w_accept) begin
                r_sum <= r_sum + SUM_W'(i_sample) - SUM_W'(w_drop);
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // votes > held / 3 is the same as 3 * votes > held
    always_ff @(posedge i_clk) begin
        if (r_state == S_COUNT) begin
            r_trig <= w_vote_x3 > (CNT_W+2)'(r_fill);
        end
        if (w_load_out) begin
            r_out_trig <= r_trig;
            r_out_avg  <= w_quo[SAMPLE_W-1:0];
            r_out_held <= HELD_W'(r_fill);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_triggered  = r_out_trig;
    assign o_average    = r_out_avg;
    assign o_held_count = r_out_held;

endmodule

// File: rtl/wta_cell.sv
// ----------------------------------------------------------------------------
// wta_cell: one window slot
// Holds one sample, hands it to the next slot on a shift and flags whether
// the held sample sits above base plus threshold.
// ----------------------------------------------------------------------------
module wta_cell
    import wta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_cell_data i_prev,
    input  t_cmp_cfg   i_cmp,
    output t_cell_data o_data,
    output logic       o_vote
);

    logic                     r_valid;
    logic [SAMPLE_W-1:0]      r_sample;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_prev.sample;
        end
    end

    assign w_diff = $signed({2'b00, r_sample}) - $signed({2'b00, i_cmp.base});
    assign w_thr  = DIFF_W'(i_cmp.thr);
    assign o_vote = r_valid && (w_diff > w_thr);

    assign o_data.valid  = r_valid;
    assign o_data.sample = r_sample;

endmodule

// File: rtl/wta_div.sv
// ----------------------------------------------------------------------------
// wta_div: restoring divider for the window mean
// Produces one quotient bit per cycle; the quotient holds until next start.
// ----------------------------------------------------------------------------
module wta_div
    import wta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [SUM_W-1:0] o_quotient
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W:0]    w_sh;
    logic [CNT_W:0]    w_diff;
    logic              w_fit;

    assign w_sh   = {r_rem, r_quo[SUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_div};
    assign w_fit  = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            // shift in one quotient bit, subtract when the divisor fits
            if (w_fit) begin
                r_rem <= w_diff[CNT_W-1:0];
            end else begin
                r_rem <= w_sh[CNT_W-1:0];
            end
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
